// File: sv/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types, constants and helper functions of the RGBA half downsampler.
// ----------------------------------------------------------------------------
`default_nettype none

package rhd_pkg;

    // pixel channel and pair sum widths
    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 4 * CHAN_W;
    localparam int PAIR_CH_W = CHAN_W + 1;
    localparam int PAIR_W    = 4 * PAIR_CH_W;

    // configuration port
    localparam int CFG_W     = 13;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;

    // default raster limits
    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    // register index, taken from paddr[2]
    typedef enum logic [0:0] {
        REG_SOURCE_WIDTH  = 1'b0,
        REG_SOURCE_HEIGHT = 1'b1
    } reg_index_t;

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [PAIR_W-1:0]  pair_t;

    // four 9-bit channel sums of two packed pixels, red in the low field
    function automatic pair_t pair_sum(input pixel_t a, input pixel_t b);
        pair_t r;
        r = '0;
        for (int c = 0; c < 4; c++)
        begin
            r[c*PAIR_CH_W +: PAIR_CH_W] = {1'b0, a[c*CHAN_W +: CHAN_W]}
                                        + {1'b0, b[c*CHAN_W +: CHAN_W]};
        end
        return r;
    endfunction

    // truncated mean of the four pixels in two pair sums, packed as a pixel
    function automatic pixel_t pair_mean(input pair_t u, input pair_t l);
        pixel_t r;
        logic [PAIR_CH_W:0] s;
        r = '0;
        for (int c = 0; c < 4; c++)
        begin
            s = {1'b0, u[c*PAIR_CH_W +: PAIR_CH_W]} + {1'b0, l[c*PAIR_CH_W +: PAIR_CH_W]};
            r[c*CHAN_W +: CHAN_W] = s[PAIR_CH_W:2];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/rhd_in_if.sv
// ----------------------------------------------------------------------------
// rhd_in_if
// Source pixel channel: valid/ready handshake with one RGBA8 pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhd_in_if;
    logic                      valid;
    logic                      ready;
    logic [rhd_pkg::CHAN_W-1:0] red_in;
    logic [rhd_pkg::CHAN_W-1:0] green_in;
    logic [rhd_pkg::CHAN_W-1:0] blue_in;
    logic [rhd_pkg::CHAN_W-1:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

`default_nettype wire

// File: sv/rhd_out_if.sv
// ----------------------------------------------------------------------------
// rhd_out_if
// Result pixel channel: valid/ready handshake with one filtered pixel
// and its row and frame end marks.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhd_out_if;
    logic                      valid;
    logic                      ready;
    logic [rhd_pkg::CHAN_W-1:0] red_out;
    logic [rhd_pkg::CHAN_W-1:0] green_out;
    logic [rhd_pkg::CHAN_W-1:0] blue_out;
    logic [rhd_pkg::CHAN_W-1:0] alpha_out;
    logic                      row_end;
    logic                      frame_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output row_end, output frame_end, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

// File: sv/rhd_line_ram.sv
// ----------------------------------------------------------------------------
// rhd_line_ram
// Line store of horizontal pair sums: one write port, one read port,
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_line_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             waddr,
    input  wire rhd_pkg::pair_t            wdata,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             raddr,
    output rhd_pkg::pair_t                 rdata
);

    rhd_pkg::pair_t mem [DEPTH];
    rhd_pkg::pair_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/rhd_cfg.sv
// ----------------------------------------------------------------------------
// rhd_cfg
// APB register file for the source size; keeps the raw register values for
// readback and the clamped dimensions used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_cfg #(
    parameter int MAX_WIDTH  = rhd_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = rhd_pkg::DEFAULT_MAX_HEIGHT,
    parameter int WW  = $clog2(MAX_WIDTH + 1),
    parameter int HW  = $clog2(MAX_HEIGHT + 1),
    parameter int OWW = $clog2((MAX_WIDTH + 1) / 2 + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rhd_pkg::APB_AW-1:0]   paddr,
    input  wire logic [rhd_pkg::APB_DW-1:0]   pwdata,
    output logic [rhd_pkg::APB_DW-1:0]        prdata,
    output logic [WW-1:0]                     width_eff,
    output logic [HW-1:0]                     height_eff,
    output logic [OWW-1:0]                    out_width
);

    localparam int CFG_W = rhd_pkg::CFG_W;
    localparam int EWW   = (WW > CFG_W) ? WW : CFG_W;
    localparam int EHW   = (HW > CFG_W) ? HW : CFG_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [WW-1:0]    width_eff_reg;
    logic [HW-1:0]    height_eff_reg;
    logic [OWW-1:0]   out_width_reg;
    logic             wr_en;
    logic [CFG_W-1:0] wr_value;

    // zero acts as one, values past the limit act as the limit
    function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
        logic [EWW-1:0] e;
        e = EWW'(v);
        if (e == '0)
        begin
            e = EWW'(1);
        end
        else if (e > EWW'(MAX_WIDTH))
        begin
            e = EWW'(MAX_WIDTH);
        end
        return WW'(e);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
        logic [EHW-1:0] e;
        e = EHW'(v);
        if (e == '0)
        begin
            e = EHW'(1);
        end
        else if (e > EHW'(MAX_HEIGHT))
        begin
            e = EHW'(MAX_HEIGHT);
        end
        return HW'(e);
    endfunction

    // half width rounded up
    function automatic logic [OWW-1:0] half_up(input logic [WW-1:0] w);
        logic [WW:0] s;
        s = {1'b0, w} + (WW+1)'(1);
        return OWW'(s >> 1);
    endfunction

    assign wr_en    = psel && penable && pwrite;
    assign wr_value = pwdata[CFG_W-1:0];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= rhd_pkg::DIM_RESET;
            height_reg     <= rhd_pkg::DIM_RESET;
            width_eff_reg  <= clamp_w(rhd_pkg::DIM_RESET);
            height_eff_reg <= clamp_h(rhd_pkg::DIM_RESET);
            out_width_reg  <= half_up(clamp_w(rhd_pkg::DIM_RESET));
        end
        else if (wr_en)
        begin
            unique case (rhd_pkg::reg_index_t'(paddr[2]))
                rhd_pkg::REG_SOURCE_WIDTH:
                begin
                    width_reg     <= wr_value;
                    width_eff_reg <= clamp_w(wr_value);
                    out_width_reg <= half_up(clamp_w(wr_value));
                end
                rhd_pkg::REG_SOURCE_HEIGHT:
                begin
                    height_reg     <= wr_value;
                    height_eff_reg <= clamp_h(wr_value);
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    // readback
    always_comb
    begin
        unique case (rhd_pkg::reg_index_t'(paddr[2]))
            rhd_pkg::REG_SOURCE_WIDTH:  prdata = rhd_pkg::APB_DW'(width_reg);
            rhd_pkg::REG_SOURCE_HEIGHT: prdata = rhd_pkg::APB_DW'(height_reg);
            default:                    prdata = '0;
        endcase
    end

    assign width_eff  = width_eff_reg;
    assign height_eff = height_eff_reg;
    assign out_width  = out_width_reg;

endmodule

`default_nettype wire

// File: sv/rgba_half_downsampler.sv
// ----------------------------------------------------------------------------
// rgba_half_downsampler
// 2x2 box filter mipmap step for an RGBA8 raster streamed in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in takes one source pixel per cycle when ready, in raster order; pix_out
//   gives one filtered pixel per 2x2 source block, with row_end on the last
//   pixel of each output row and frame_end on the last pixel of the raster.
//   Source width and height are set over the APB port (0x0 and 0x4) while
//   the block is idle; odd sizes repeat the last column or row.
// Timing:
//   a result passes the staging and output registers after the pixel that
//   completes its block is taken. The block sustains one pixel per cycle
//   unless pix_out is held; each pixel does at most one access to the
//   pair sum line RAM (even rows write, odd rows read, one port each).
// Reset:
//   counters and the left pixel clear, sizes return to 4096 (clamped to
//   MAX_WIDTH/MAX_HEIGHT). The line RAM is not cleared and needs no sweep.
// Stall:
//   when pix_out is held, one more result waits in the staging register;
//   after that pix_in.ready drops until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_half_downsampler #(
    parameter int MAX_WIDTH  = rhd_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = rhd_pkg::DEFAULT_MAX_HEIGHT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rhd_pkg::APB_AW-1:0]  paddr,
    input  wire logic [rhd_pkg::APB_DW-1:0]  pwdata,
    output logic [rhd_pkg::APB_DW-1:0]       prdata,
    output logic                             pready,
    rhd_in_if.sink                           pix_in,
    rhd_out_if.source                        pix_out
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CBW   = $clog2(MAX_WIDTH);
    localparam int RBW   = $clog2(MAX_HEIGHT);
    localparam int DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OWW   = $clog2(DEPTH + 1);
    localparam int CW    = rhd_pkg::CHAN_W;

    typedef struct packed {
        logic           use_line;
        logic           row_end;
        logic           frame_end;
        rhd_pkg::pair_t pair;
    } stage_t;

    logic [WW-1:0]    width_eff;
    logic [HW-1:0]    height_eff;
    logic [OWW-1:0]   out_width;

    logic [CBW-1:0]   col_reg;
    logic [CBW-1:0]   col_next;
    logic [RBW-1:0]   row_reg;
    logic [RBW-1:0]   row_next;
    rhd_pkg::pixel_t  left_pixel_reg;

    rhd_pkg::pixel_t  pix;
    logic             accept;
    logic             last_col;
    logic             last_row;
    logic             col_odd;
    logic             row_odd;
    logic             have_pair;
    logic             emit;
    logic [AW-1:0]    idx;
    rhd_pkg::pair_t   pair;
    stage_t           stage_in;

    logic             s1_valid_reg;
    stage_t           s1_reg;
    logic             out_valid_reg;
    rhd_pkg::pixel_t  out_pix_reg;
    logic             out_row_end_reg;
    logic             out_frame_end_reg;
    logic             out_free;
    logic             s1_move;
    logic             mem_we;
    logic             mem_re;
    rhd_pkg::pair_t   line_rdata;
    rhd_pkg::pair_t   upper;

    // configuration registers
    rhd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW),
        .OWW        (OWW)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .out_width  (out_width)
    );

    assign pready = 1'b1;

    // handshake
    assign out_free     = !out_valid_reg || pix_out.ready;
    assign s1_move      = s1_valid_reg && out_free;
    assign pix_in.ready = !s1_valid_reg || out_free;
    assign accept       = pix_in.valid && pix_in.ready;

    // position decode of the incoming pixel
    assign pix      = {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in, pix_in.red_in};
    assign last_col = (WW'(col_reg) + WW'(1)) >= width_eff;
    assign last_row = (HW'(row_reg) + HW'(1)) >= height_eff;
    assign col_odd  = col_reg[0];
    assign row_odd  = row_reg[0];
    assign idx      = AW'(col_reg >> 1);

    // horizontal pair, right pixel repeated at an odd width
    assign pair      = col_odd ? rhd_pkg::pair_sum(left_pixel_reg, pix)
                               : rhd_pkg::pair_sum(pix, pix);
    assign have_pair = col_odd || last_col;
    assign emit      = have_pair && (row_odd || last_row);

    // line RAM access: even rows store, odd rows fetch the upper pair
    assign mem_we = accept && have_pair && !row_odd && !last_row;
    assign mem_re = accept && have_pair && row_odd;

    always_comb
    begin
        stage_in.use_line  = row_odd;
        stage_in.row_end   = (OWW'(idx) + OWW'(1)) >= out_width;
        stage_in.frame_end = stage_in.row_end && last_row;
        stage_in.pair      = pair;
    end

    rhd_line_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx),
        .wdata (pair),
        .re    (mem_re),
        .raddr (idx),
        .rdata (line_rdata)
    );

    // counter update
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RBW'(1);
        end
        else
        begin
            col_next = col_reg + CBW'(1);
        end
    end

    // position and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_pixel_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                if (!col_odd)
                begin
                    left_pixel_reg <= pix;
                end
            end
            if (accept)
            begin
                s1_valid_reg <= emit;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // staging register, waits for the line RAM read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage_in;
        end
    end

    // vertical sum and output register
    assign upper = s1_reg.use_line ? line_rdata : s1_reg.pair;

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_pix_reg       <= rhd_pkg::pair_mean(upper, s1_reg.pair);
            out_row_end_reg   <= s1_reg.row_end;
            out_frame_end_reg <= s1_reg.frame_end;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = out_pix_reg[0*CW +: CW];
    assign pix_out.green_out = out_pix_reg[1*CW +: CW];
    assign pix_out.blue_out  = out_pix_reg[2*CW +: CW];
    assign pix_out.alpha_out = out_pix_reg[3*CW +: CW];
    assign pix_out.row_end   = out_row_end_reg;
    assign pix_out.frame_end = out_frame_end_reg;

endmodule

`default_nettype wire
